>>> rtl/fdsa_pkg.sv
// ----------------------------------------------------------------------------
// fdsa_pkg
// shared types and constants for the forth data stack alu unit
// ----------------------------------------------------------------------------
package fdsa_pkg;

   // field widths
   localparam int DATA_W          = 32;
   localparam int MODE_W          = 4;
   localparam int STATUS_W        = 2;
   localparam int DEPTH_W         = 7;
   localparam int STACK_DEPTH_DEF = 64;

   // word codes carried in the request
   typedef enum logic [MODE_W-1:0] {
      MODE_PUSH     = 4'd0,
      MODE_DUP      = 4'd1,
      MODE_DROP     = 4'd2,
      MODE_LESS     = 4'd3,
      MODE_GREATER  = 4'd4,
      MODE_EQUAL    = 4'd5,
      MODE_DIVIDE   = 4'd6,
      MODE_MULTIPLY = 4'd7,
      MODE_SUBTRACT = 4'd8,
      MODE_ADD      = 4'd9,
      MODE_PRINT    = 4'd10
   } mode_type;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_UNDER = 2'd1,
      STATUS_OVER  = 2'd2,
      STATUS_DIVZ  = 2'd3
   } status_type;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_FETCH = 2'd1,
      ST_DIV   = 2'd2,
      ST_DONE  = 2'd3
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic load;       // latch request, read top two entries
      logic fetch;      // operands valid, register alu result and status
      logic div_start;  // launch the iterative divider
      logic commit;     // update stack and load response register
   } ctrl_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic div_go;     // divide word with valid operands and a nonzero divisor
      logic div_done;   // divider quotient ready
   } dp_stat_type;

endpackage

>>> rtl/fdsa_div.sv
// ----------------------------------------------------------------------------
// fdsa_div
// radix-2 restoring signed divider, quotient truncated toward zero
// ----------------------------------------------------------------------------
module fdsa_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [fdsa_pkg::DATA_W-1:0]   dividend,
   input  logic [fdsa_pkg::DATA_W-1:0]   divisor,
   output logic                          done,
   output logic [fdsa_pkg::DATA_W-1:0]   quotient
);

   localparam int DW = fdsa_pkg::DATA_W;
   localparam int SW = $clog2(DW);

   logic          busy_ff;
   logic          fin_ff;
   logic [SW-1:0] step_ff;
   logic          neg_ff;
   logic [DW-1:0] rem_ff;
   logic [DW-1:0] quo_ff;
   logic [DW-1:0] dvs_ff;

   logic [DW:0]   shifted;
   logic [DW:0]   trial;

   // one quotient bit per cycle
   assign shifted = {rem_ff, quo_ff[DW-1]};
   assign trial   = shifted - {1'b0, dvs_ff};

   // control: busy while the quotient bits are resolved, then a done pulse
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         step_ff <= '0;
      end else begin
         fin_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + SW'(1);
            if (step_ff == SW'(DW - 1)) begin
               busy_ff <= 1'b0;
               fin_ff  <= 1'b1;
            end
         end
      end
   end

   // operand magnitudes and partial remainder
   always_ff @(posedge clock) begin
      if (start) begin
         neg_ff <= dividend[DW-1] ^ divisor[DW-1];
         rem_ff <= '0;
         quo_ff <= dividend[DW-1] ? (DW'(0) - dividend) : dividend;
         dvs_ff <= divisor[DW-1] ? (DW'(0) - divisor) : divisor;
      end else if (busy_ff) begin
         if (!trial[DW]) begin
            rem_ff <= trial[DW-1:0];
            quo_ff <= {quo_ff[DW-2:0], 1'b1};
         end else begin
            rem_ff <= shifted[DW-1:0];
            quo_ff <= {quo_ff[DW-2:0], 1'b0};
         end
      end
   end

   // sign fix on the way out
   assign done     = fin_ff;
   assign quotient = neg_ff ? (DW'(0) - quo_ff) : quo_ff;

endmodule

>>> rtl/fdsa_dpath.sv
// ----------------------------------------------------------------------------
// fdsa_dpath
// stack memory, depth counter, alu, divider and response register
// ----------------------------------------------------------------------------
module fdsa_dpath #(
   parameter int STACK_DEPTH = fdsa_pkg::STACK_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  fdsa_pkg::ctrl_cmd_type         cmd,
   output fdsa_pkg::dp_stat_type          stat,
   input  logic [fdsa_pkg::MODE_W-1:0]    req_mode,
   input  logic [fdsa_pkg::DATA_W-1:0]    req_literal,
   output logic [fdsa_pkg::STATUS_W-1:0]  rsp_status,
   output logic                           rsp_print_valid,
   output logic [fdsa_pkg::DATA_W-1:0]    rsp_print_value,
   output logic [fdsa_pkg::DEPTH_W-1:0]   rsp_depth
);

   localparam int DW = fdsa_pkg::DATA_W;
   localparam int AW = $clog2(STACK_DEPTH);
   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

   logic [DW-1:0] stack_mem [STACK_DEPTH];

   fdsa_pkg::mode_type   mode_ff;
   fdsa_pkg::mode_type   req_word;
   fdsa_pkg::status_type err_ff;
   fdsa_pkg::status_type err_in;
   fdsa_pkg::status_type status_ff;
   logic [DW-1:0]        lit_ff;
   logic [DW-1:0]        opr_ff;
   logic [DW-1:0]        opl_ff;
   logic [DW-1:0]        res_ff;
   logic [DW-1:0]        res_in;
   logic [CW-1:0]        cnt_ff;
   logic [CW-1:0]        cnt_in;

   logic [fdsa_pkg::STATUS_W-1:0] out_status_ff;
   logic                          out_pv_ff;
   logic [DW-1:0]                 out_pval_ff;
   logic [fdsa_pkg::DEPTH_W-1:0]  out_depth_ff;

   logic [AW-1:0] addr_r;
   logic [AW-1:0] addr_l;
   logic          req_unary;
   logic          req_binary;
   logic          op_grow;
   logic          op_shrink;
   logic          op_binary;
   logic          ok;
   logic          mem_we;
   logic [AW-1:0] mem_wa;
   logic [DW-1:0] mem_wd;
   logic [DW-1:0] quotient;
   logic          div_done;

   // request checks against the current depth
   assign req_word   = fdsa_pkg::mode_type'(req_mode);
   assign req_unary  = (req_word == fdsa_pkg::MODE_DUP) || (req_word == fdsa_pkg::MODE_DROP)
                       || (req_word == fdsa_pkg::MODE_PRINT);
   assign req_binary = (req_mode >= fdsa_pkg::MODE_LESS) && (req_mode <= fdsa_pkg::MODE_ADD);

   always_comb begin
      if (req_unary && (cnt_ff == '0)) begin
         err_in = fdsa_pkg::STATUS_UNDER;
      end else if (req_binary && (cnt_ff < CW'(2))) begin
         err_in = fdsa_pkg::STATUS_UNDER;
      end else if (((req_word == fdsa_pkg::MODE_PUSH) || (req_word == fdsa_pkg::MODE_DUP))
                   && (cnt_ff == FULL)) begin
         err_in = fdsa_pkg::STATUS_OVER;
      end else begin
         err_in = fdsa_pkg::STATUS_OK;
      end
   end

   // read addresses of the top two entries
   assign addr_r = cnt_ff[AW-1:0] - AW'(1);
   assign addr_l = cnt_ff[AW-1:0] - AW'(2);

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= req_word;
         lit_ff  <= req_literal;
         err_ff  <= err_in;
      end
   end

   // stack memory, registered reads
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         opr_ff <= stack_mem[addr_r];
         opl_ff <= stack_mem[addr_l];
      end
      if (mem_we) begin
         stack_mem[mem_wa] <= mem_wd;
      end
   end

   // combinational alu words, registered on fetch
   always_comb begin
      case (mode_ff)
         fdsa_pkg::MODE_LESS:     res_in = DW'($signed(opl_ff) < $signed(opr_ff));
         fdsa_pkg::MODE_GREATER:  res_in = DW'($signed(opr_ff) < $signed(opl_ff));
         fdsa_pkg::MODE_EQUAL:    res_in = DW'(opl_ff == opr_ff);
         fdsa_pkg::MODE_MULTIPLY: res_in = opl_ff * opr_ff;
         fdsa_pkg::MODE_SUBTRACT: res_in = opl_ff - opr_ff;
         default:                 res_in = opl_ff + opr_ff;
      endcase
   end

   assign stat.div_go   = (err_ff == fdsa_pkg::STATUS_OK) && (mode_ff == fdsa_pkg::MODE_DIVIDE)
                          && (opr_ff != '0);
   assign stat.div_done = div_done;

   // alu result and final status
   always_ff @(posedge clock) begin
      if (cmd.fetch) begin
         res_ff <= res_in;
         if ((err_ff == fdsa_pkg::STATUS_OK) && (mode_ff == fdsa_pkg::MODE_DIVIDE)
             && (opr_ff == '0)) begin
            status_ff <= fdsa_pkg::STATUS_DIVZ;
         end else begin
            status_ff <= err_ff;
         end
      end
   end

   fdsa_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (opl_ff),
      .divisor  (opr_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   // stack update on commit
   assign ok        = (status_ff == fdsa_pkg::STATUS_OK);
   assign op_binary = (mode_ff >= fdsa_pkg::MODE_LESS) && (mode_ff <= fdsa_pkg::MODE_ADD);
   assign op_grow   = (mode_ff == fdsa_pkg::MODE_PUSH) || (mode_ff == fdsa_pkg::MODE_DUP);
   assign op_shrink = op_binary || (mode_ff == fdsa_pkg::MODE_DROP)
                      || (mode_ff == fdsa_pkg::MODE_PRINT);
   assign mem_we    = cmd.commit && ok && (op_grow || op_binary);
   assign mem_wa    = op_grow ? cnt_ff[AW-1:0] : addr_l;

   always_comb begin
      if (mode_ff == fdsa_pkg::MODE_PUSH) begin
         mem_wd = lit_ff;
      end else if (mode_ff == fdsa_pkg::MODE_DUP) begin
         mem_wd = opr_ff;
      end else if (mode_ff == fdsa_pkg::MODE_DIVIDE) begin
         mem_wd = quotient;
      end else begin
         mem_wd = res_ff;
      end
   end

   always_comb begin
      if (ok && op_grow) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (ok && op_shrink) begin
         cnt_in = cnt_ff - CW'(1);
      end else begin
         cnt_in = cnt_ff;
      end
   end

   // depth counter
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.commit) begin
         cnt_ff <= cnt_in;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         out_status_ff <= status_ff;
         out_pv_ff     <= ok && (mode_ff == fdsa_pkg::MODE_PRINT);
         out_pval_ff   <= (ok && (mode_ff == fdsa_pkg::MODE_PRINT)) ? opr_ff : '0;
         out_depth_ff  <= fdsa_pkg::DEPTH_W'(cnt_in);
      end
   end

   assign rsp_status      = out_status_ff;
   assign rsp_print_valid = out_pv_ff;
   assign rsp_print_value = out_pval_ff;
   assign rsp_depth       = out_depth_ff;

   // depth never passes the stack size
   assert property (@(posedge clock) disable iff (reset) cnt_ff <= FULL)
      else $error("stack count beyond stack depth");

   // a good push grows the stack by exactly one
   assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && ok && (mode_ff == fdsa_pkg::MODE_PUSH))
      |=> (cnt_ff == $past(cnt_ff) + CW'(1)))
      else $error("push did not grow the stack");

endmodule

>>> rtl/fdsa_ctrl.sv
// ----------------------------------------------------------------------------
// fdsa_ctrl
// sequencer for one word: accept, operand fetch, divide wait, commit
// ----------------------------------------------------------------------------
module fdsa_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output fdsa_pkg::ctrl_cmd_type   cmd,
   input  fdsa_pkg::dp_stat_type    stat
);

   fdsa_pkg::state_type state_ff;
   fdsa_pkg::state_type state_in;
   logic                rsp_valid_ff;
   logic                out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fdsa_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fdsa_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = fdsa_pkg::ST_FETCH;
            end
         end
         fdsa_pkg::ST_FETCH: begin
            state_in = stat.div_go ? fdsa_pkg::ST_DIV : fdsa_pkg::ST_DONE;
         end
         fdsa_pkg::ST_DIV: begin
            if (stat.div_done) begin
               state_in = fdsa_pkg::ST_DONE;
            end
         end
         fdsa_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = fdsa_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fdsa_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         fdsa_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         fdsa_pkg::ST_FETCH: begin
            cmd.fetch     = 1'b1;
            cmd.div_start = stat.div_go;
         end
         fdsa_pkg::ST_DONE: begin
            cmd.commit = out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   // response valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   // a pending response is never overwritten
   assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_valid_ff || rsp_tready))
      else $error("response overwritten before transaction");

   // divider finishes only while the sequencer waits for it
   assert property (@(posedge clock) disable iff (reset)
      stat.div_done |-> (state_ff == fdsa_pkg::ST_DIV))
      else $error("divider done outside divide wait");

endmodule

>>> rtl/forth_data_stack_alu_unit.sv
// ----------------------------------------------------------------------------
// forth_data_stack_alu_unit
// forth data stack with integer alu, one response per request word
// ----------------------------------------------------------------------------
// usage:
//   req channel carries one word per transaction: the word code in tuser and
//   the literal (used by push only) in tdata. rsp channel returns one
//   response per word: status and print flag in tuser, printed value and
//   stack depth in tdata.
//   rsp_tvalid rises once the word has passed the fetch and done states;
//   a divide word also waits in the divide state while the radix-2 divider
//   resolves one quotient bit per cycle and then raises its registered done
//   flag. a new request is taken only after the response of the previous
//   word is loaded, once the sequencer is back in idle.
//   the stack store is a single memory with two registered read ports;
//   the operand fetch cycle comes from its read register.
//   reset clears the depth counter and the response valid flag; the stack
//   memory itself is not cleared and needs no sweep.
//   when the receiver stalls, the response register holds; a new request is
//   still taken and worked, and its result waits until the held response
//   has completed its transaction.
// ----------------------------------------------------------------------------
module forth_data_stack_alu_unit #(
   parameter int STACK_DEPTH = fdsa_pkg::STACK_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] literal
   input  logic [3:0]  req_tuser,   // [3:0] mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] print_value, [38:32] depth, [39] zero
   output logic [2:0]  rsp_tuser    // [1:0] status, [2] print_valid
);

   fdsa_pkg::ctrl_cmd_type cmd;
   fdsa_pkg::dp_stat_type  stat;

   logic [fdsa_pkg::STATUS_W-1:0] rsp_status;
   logic                          rsp_print_valid;
   logic [fdsa_pkg::DATA_W-1:0]   rsp_print_value;
   logic [fdsa_pkg::DEPTH_W-1:0]  rsp_depth;

   fdsa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   fdsa_dpath #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_mode        (req_tuser),
      .req_literal     (req_tdata),
      .rsp_status      (rsp_status),
      .rsp_print_valid (rsp_print_valid),
      .rsp_print_value (rsp_print_value),
      .rsp_depth       (rsp_depth)
   );

   // response packing
   assign rsp_tdata = {1'b0, rsp_depth, rsp_print_value};
   assign rsp_tuser = {rsp_print_valid, rsp_status};

endmodule

>>> verif/fdsa_result_checker.sv
// ----------------------------------------------------------------------------
// fdsa_result_checker
// response predictor and scoreboard for the forth data stack alu unit
// ----------------------------------------------------------------------------
// watches the req and rsp channels at the rising clock edge. every accepted
// request word runs through a private copy of the stack and alu, and the
// predicted response waits in order until the matching rsp transaction
// arrives. responses are compared field by field, including the zero pad bit
// of rsp_tdata. the first ten mismatches are printed, the rest only counted.
// ----------------------------------------------------------------------------
module fdsa_result_checker #(
   parameter int STACK_DEPTH = fdsa_pkg::STACK_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] literal
   input  logic [3:0]  req_tuser,   // [3:0] mode
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,   // [31:0] print_value, [38:32] depth, [39] zero
   input  logic [2:0]  rsp_tuser,   // [1:0] status, [2] print_valid
   output int          mismatch_count,
   output int          pending_count,
   output int          checked_count,
   output int          fault_count,
   output int          print_count
);

   localparam int REPORT_LIMIT = 10;
   localparam int DW           = fdsa_pkg::DATA_W;

   // one response as the unit should return it
   typedef struct packed {
      fdsa_pkg::status_type            status;
      logic                            print_valid;
      logic [fdsa_pkg::DATA_W-1:0]     print_value;
      logic [fdsa_pkg::DEPTH_W-1:0]    depth;
   } word_result_type;

   // private copy of the data stack
   logic [DW-1:0]     shadow_stack [STACK_DEPTH];
   int                shadow_count;

   word_result_type   pending_results [$];

   // execute one word on the shadow stack and return the expected response
   function automatic word_result_type exec_word(input logic [fdsa_pkg::MODE_W-1:0] mode,
                                                 input logic [DW-1:0] lit);
      word_result_type   r;
      logic [DW-1:0]     rhs;
      logic [DW-1:0]     lhs;
      logic [DW-1:0]     res;
      logic [DW-1:0]     mag_l;
      logic [DW-1:0]     mag_r;
      logic [DW-1:0]     quot;
      r.status      = fdsa_pkg::STATUS_OK;
      r.print_valid = 1'b0;
      r.print_value = '0;
      res           = '0;
      case (mode)
         fdsa_pkg::MODE_PUSH: begin
            if (shadow_count >= STACK_DEPTH) begin
               r.status = fdsa_pkg::STATUS_OVER;
            end else begin
               shadow_stack[shadow_count] = lit;
               shadow_count++;
            end
         end
         fdsa_pkg::MODE_DUP: begin
            if (shadow_count < 1) begin
               r.status = fdsa_pkg::STATUS_UNDER;
            end else if (shadow_count >= STACK_DEPTH) begin
               r.status = fdsa_pkg::STATUS_OVER;
            end else begin
               shadow_stack[shadow_count] = shadow_stack[shadow_count-1];
               shadow_count++;
            end
         end
         fdsa_pkg::MODE_DROP, fdsa_pkg::MODE_PRINT: begin
            if (shadow_count < 1) begin
               r.status = fdsa_pkg::STATUS_UNDER;
            end else begin
               shadow_count--;
               if (mode == fdsa_pkg::MODE_PRINT) begin
                  r.print_valid = 1'b1;
                  r.print_value = shadow_stack[shadow_count];
               end
            end
         end
         fdsa_pkg::MODE_LESS, fdsa_pkg::MODE_GREATER, fdsa_pkg::MODE_EQUAL,
         fdsa_pkg::MODE_DIVIDE, fdsa_pkg::MODE_MULTIPLY, fdsa_pkg::MODE_SUBTRACT,
         fdsa_pkg::MODE_ADD: begin
            if (shadow_count < 2) begin
               r.status = fdsa_pkg::STATUS_UNDER;
            end else begin
               // top of stack is the right operand
               rhs = shadow_stack[shadow_count-1];
               lhs = shadow_stack[shadow_count-2];
               case (mode)
                  fdsa_pkg::MODE_LESS:
                     res = ($signed(lhs) < $signed(rhs)) ? 32'd1 : 32'd0;
                  fdsa_pkg::MODE_GREATER:
                     res = ($signed(lhs) > $signed(rhs)) ? 32'd1 : 32'd0;
                  fdsa_pkg::MODE_EQUAL:
                     res = (lhs == rhs) ? 32'd1 : 32'd0;
                  fdsa_pkg::MODE_DIVIDE: begin
                     if (rhs == '0) begin
                        r.status = fdsa_pkg::STATUS_DIVZ;
                     end else begin
                        // divide magnitudes, truncate toward zero, wrap on overflow
                        mag_l = lhs[DW-1] ? -lhs : lhs;
                        mag_r = rhs[DW-1] ? -rhs : rhs;
                        quot  = mag_l / mag_r;
                        res   = (lhs[DW-1] != rhs[DW-1]) ? -quot : quot;
                     end
                  end
                  fdsa_pkg::MODE_MULTIPLY: res = lhs * rhs;
                  fdsa_pkg::MODE_SUBTRACT: res = lhs - rhs;
                  default:                 res = lhs + rhs;
               endcase
               if (r.status == fdsa_pkg::STATUS_OK) begin
                  shadow_count--;
                  shadow_stack[shadow_count-1] = res;
               end
            end
         end
         // spare codes leave everything as it is
         default: ;
      endcase
      r.depth = shadow_count[fdsa_pkg::DEPTH_W-1:0];
      return r;
   endfunction

   // sample both channels on the rising edge, compare and predict
   always @(posedge clock) begin : monitor
      word_result_type seen;
      word_result_type want;
      if (reset) begin
         pending_results.delete();
         shadow_count = 0;
      end else begin
         // response transaction: compare against the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            seen.status      = fdsa_pkg::status_type'(rsp_tuser[1:0]);
            seen.print_valid = rsp_tuser[2];
            seen.print_value = rsp_tdata[31:0];
            seen.depth       = rsp_tdata[38:32];
            if (pending_results.size() == 0) begin
               if (mismatch_count < REPORT_LIMIT)
                  $display("unexpected response: status %0d print %0b value %h depth %0d",
                           seen.status, seen.print_valid, seen.print_value, seen.depth);
               mismatch_count++;
            end else begin
               want = pending_results.pop_front();
               checked_count++;
               if (want.status != fdsa_pkg::STATUS_OK) fault_count++;
               if (want.print_valid) print_count++;
               if (seen !== want || rsp_tdata[39] !== 1'b0) begin
                  if (mismatch_count < REPORT_LIMIT)
                     $display({"mismatch on response %0d: expected status %0d print %0b ",
                               "value %h depth %0d, got status %0d print %0b value %h ",
                               "depth %0d pad %b"},
                              checked_count, want.status, want.print_valid,
                              want.print_value, want.depth, seen.status,
                              seen.print_valid, seen.print_value, seen.depth,
                              rsp_tdata[39]);
                  mismatch_count++;
               end
            end
         end
         // request transaction: predict its response
         if (req_tvalid && req_tready)
            pending_results.push_back(exec_word(req_tuser, req_tdata));
         pending_count = pending_results.size();
      end
   end

endmodule

>>> verif/tb_forth_data_stack_alu_unit.sv
// ----------------------------------------------------------------------------
// tb_forth_data_stack_alu_unit
// self-checking testbench for the forth data stack alu unit
// ----------------------------------------------------------------------------
// a directed run of stack words covers underflow on every word class, spare
// codes, wrap of add, most negative divided by minus one, divide by zero
// and truncation toward zero. random words follow, steered between filling
// and draining the stack so that overflow and underflow recur. pacing runs
// in three phases: slow receiver, slow sender, then no idling at all.
// checking is done by fdsa_result_checker.
// ----------------------------------------------------------------------------
module tb_forth_data_stack_alu_unit;

   localparam int STACK_DEPTH  = fdsa_pkg::STACK_DEPTH_DEF;
   localparam int MW           = fdsa_pkg::MODE_W;
   localparam int DW           = fdsa_pkg::DATA_W;
   localparam int RANDOM_WORDS = 1400;
   localparam int STALL_LIMIT  = 3000;
   localparam int DRAIN_CYCLES = 40;

   // codes outside the word set, which the unit ignores
   localparam logic [MW-1:0] MODE_SPARE_FIRST = 4'd11;
   localparam logic [MW-1:0] MODE_SPARE_LAST  = 4'd15;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;   // [31:0] literal
   logic [3:0]  req_tuser;   // [3:0] mode
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;   // [31:0] print_value, [38:32] depth, [39] zero
   logic [2:0]  rsp_tuser;   // [1:0] status, [2] print_valid

   logic        req_fire;
   int          req_idle_pct;
   int          rsp_idle_pct;
   int          stall_cycles;
   int          est_depth;
   bit          filling;

   int          mismatch_count;
   int          pending_count;
   int          checked_count;
   int          fault_count;
   int          print_count;

   forth_data_stack_alu_unit #(.STACK_DEPTH(STACK_DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   fdsa_result_checker #(.STACK_DEPTH(STACK_DEPTH)) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count),
      .checked_count  (checked_count),
      .fault_count    (fault_count),
      .print_count    (print_count)
   );

   // clock
   always #5 clock = ~clock;

   // request transaction seen at the last rising edge
   always @(posedge clock) req_fire <= req_tvalid && req_tready;

   // receiver pacing
   always @(negedge clock) rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);

   // watchdog on cycles with no transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
         $display("simulation failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // offer one word and hold it until accepted, with random gaps ahead
   task automatic send_word(input logic [MW-1:0] mode, input logic [DW-1:0] lit);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= lit;
      do @(negedge clock); while (!req_fire);
   endtask

   // literals: small values for equal and divide by zero, extremes, full range
   function automatic logic [DW-1:0] pick_literal();
      int roll;
      roll = $urandom_range(99);
      if (roll < 30) return 32'($urandom_range(8)) - 32'd4;
      if (roll < 40) begin
         case ($urandom_range(3))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'hffff_ffff;
            default: return 32'h0000_0000;
         endcase
      end
      return $urandom();
   endfunction

   // word choice biased toward growing or shrinking the stack
   function automatic logic [MW-1:0] pick_mode(input bit grow);
      int roll;
      roll = $urandom_range(99);
      if (grow) begin
         if (roll < 55) return fdsa_pkg::MODE_PUSH;
         if (roll < 70) return fdsa_pkg::MODE_DUP;
         if (roll < 95) return 4'($urandom_range(fdsa_pkg::MODE_ADD, fdsa_pkg::MODE_LESS));
         if (roll < 98) return $urandom_range(1) ? fdsa_pkg::MODE_DROP : fdsa_pkg::MODE_PRINT;
      end else begin
         if (roll < 15) return fdsa_pkg::MODE_PUSH;
         if (roll < 20) return fdsa_pkg::MODE_DUP;
         if (roll < 70) return 4'($urandom_range(fdsa_pkg::MODE_ADD, fdsa_pkg::MODE_LESS));
         if (roll < 97) return $urandom_range(1) ? fdsa_pkg::MODE_DROP : fdsa_pkg::MODE_PRINT;
      end
      return 4'($urandom_range(MODE_SPARE_LAST, MODE_SPARE_FIRST));
   endfunction

   // stimulus and verdict
   initial begin
      logic [MW-1:0] mode;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = '0;
      req_idle_pct = 30;
      rsp_idle_pct = 76;
      est_depth    = 0;
      filling      = 1'b1;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // directed: underflow on an empty stack for each word class
      send_word(fdsa_pkg::MODE_PRINT, $urandom());
      send_word(fdsa_pkg::MODE_DROP, $urandom());
      send_word(fdsa_pkg::MODE_DUP, $urandom());
      send_word(fdsa_pkg::MODE_ADD, $urandom());
      send_word(MODE_SPARE_FIRST, $urandom());
      send_word(fdsa_pkg::MODE_PUSH, 32'h7fff_ffff);
      send_word(fdsa_pkg::MODE_SUBTRACT, $urandom());
      // add wraps to the most negative value
      send_word(fdsa_pkg::MODE_PUSH, 32'h0000_0001);
      send_word(fdsa_pkg::MODE_ADD, $urandom());
      send_word(fdsa_pkg::MODE_DUP, $urandom());
      // most negative divided by minus one wraps
      send_word(fdsa_pkg::MODE_PUSH, 32'hffff_ffff);
      send_word(fdsa_pkg::MODE_DIVIDE, $urandom());
      send_word(fdsa_pkg::MODE_EQUAL, $urandom());
      // divide by zero leaves the stack alone
      send_word(fdsa_pkg::MODE_PUSH, 32'h0000_0000);
      send_word(fdsa_pkg::MODE_DIVIDE, $urandom());
      send_word(fdsa_pkg::MODE_DROP, $urandom());
      // negative quotient truncates toward zero
      send_word(fdsa_pkg::MODE_PUSH, -32'sd7);
      send_word(fdsa_pkg::MODE_PUSH, 32'h0000_0002);
      send_word(fdsa_pkg::MODE_DIVIDE, $urandom());
      send_word(fdsa_pkg::MODE_GREATER, $urandom());
      send_word(fdsa_pkg::MODE_PUSH, 32'h8000_0000);
      send_word(fdsa_pkg::MODE_LESS, $urandom());
      send_word(fdsa_pkg::MODE_PUSH, 32'h1234_5678);
      send_word(fdsa_pkg::MODE_MULTIPLY, $urandom());
      send_word(MODE_SPARE_LAST, $urandom());
      send_word(fdsa_pkg::MODE_PRINT, $urandom());

      // random words, steered between full and empty stack
      for (int i = 0; i < RANDOM_WORDS; i++) begin
         if (i == RANDOM_WORDS / 3) begin
            req_idle_pct = 76;
            rsp_idle_pct = 30;
         end else if (i == 2 * RANDOM_WORDS / 3) begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         if (filling && est_depth >= STACK_DEPTH && $urandom_range(3) == 0)
            filling = 1'b0;
         else if (!filling && est_depth < 2 && $urandom_range(3) == 0)
            filling = 1'b1;
         else if ($urandom_range(99) == 0)
            filling = !filling;
         mode = pick_mode(filling);
         send_word(mode, (mode == fdsa_pkg::MODE_PUSH) ? pick_literal() : $urandom());
         // rough depth estimate, only used to steer the stimulus
         case (mode)
            fdsa_pkg::MODE_PUSH:
               if (est_depth < STACK_DEPTH) est_depth++;
            fdsa_pkg::MODE_DUP:
               if (est_depth >= 1 && est_depth < STACK_DEPTH) est_depth++;
            fdsa_pkg::MODE_DROP, fdsa_pkg::MODE_PRINT:
               if (est_depth >= 1) est_depth--;
            fdsa_pkg::MODE_LESS, fdsa_pkg::MODE_GREATER, fdsa_pkg::MODE_EQUAL,
            fdsa_pkg::MODE_DIVIDE, fdsa_pkg::MODE_MULTIPLY, fdsa_pkg::MODE_SUBTRACT,
            fdsa_pkg::MODE_ADD:
               if (est_depth >= 2) est_depth--;
            default: ;
         endcase
      end
      req_tvalid <= 1'b0;

      // let every predicted response arrive, then watch for strays
      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("checked %0d responses, %0d with a fault status, %0d printed values",
               checked_count, fault_count, print_count);
      $display("stimulus: directed words then %0d random words over three pacing phases",
               RANDOM_WORDS);
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("simulation failed");
      end
      $finish;
   end

endmodule
